/* sv/pfal_pkg.sv */
// ----------------------------------------------------------------------------
// pfal_pkg
// Types and constants shared by the per-file access list table.
// ----------------------------------------------------------------------------
package pfal_pkg;

    localparam int OP_W     = 2;
    localparam int HANDLE_W = 7;
    localparam int UID_W    = 32;
    localparam int PERM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILES_W  = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // register index taken from paddr[2]
    localparam logic REG_FILES_IN_USE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LCHK,
        S_SRCH,
        S_MOVE,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [UID_W-1:0]  user;
        logic [PERM_W-1:0] mask;
    } t_entry;

    typedef struct packed {
        logic uid_eq;
        logic grant;
    } t_match;

endpackage

/* sv/pfal_entry_ram.sv */
// ----------------------------------------------------------------------------
// pfal_entry_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfal_entry_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/pfal_match.sv */
// ----------------------------------------------------------------------------
// pfal_match
// Shared compare unit: user id equality and permission overlap of one entry.
// ----------------------------------------------------------------------------
module pfal_match (
    input  logic [pfal_pkg::UID_W-1:0]  i_uid,
    input  logic [pfal_pkg::PERM_W-1:0] i_perm,
    input  pfal_pkg::t_entry            i_entry,
    output pfal_pkg::t_match            o_match
);
    import pfal_pkg::*;

    logic w_uid_eq;
    logic w_overlap;

    assign w_uid_eq  = (i_entry.user == i_uid);
    assign w_overlap = |(i_entry.mask & i_perm);

    always_comb begin
        o_match.uid_eq = w_uid_eq;
        o_match.grant  = w_uid_eq && w_overlap;
    end

endmodule

/* sv/pfal_seq.sv */
// ----------------------------------------------------------------------------
// pfal_seq
// Request sequencer: list lengths, entry walk, swap-with-last removal.
// ----------------------------------------------------------------------------
module pfal_seq #(
    parameter int FILE_SLOTS = 64,
    parameter int LIST_DEPTH = 8,
    parameter int ENT_W      = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfal_pkg::OP_W-1:0]     i_operation,
    input  logic [pfal_pkg::HANDLE_W-1:0] i_handle,
    input  logic [pfal_pkg::UID_W-1:0]    i_uid,
    input  logic [pfal_pkg::PERM_W-1:0]   i_perm,
    input  logic [pfal_pkg::FILES_W-1:0]  i_files_in_use,
    input  pfal_pkg::t_match              i_match,
    input  pfal_pkg::t_entry              i_rdata,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [pfal_pkg::STATUS_W-1:0] o_status,
    output logic                          o_granted,
    output logic [pfal_pkg::UID_W-1:0]    o_uid,
    output logic [pfal_pkg::PERM_W-1:0]   o_perm,
    output logic                          o_we,
    output logic [ENT_W-1:0]              o_waddr,
    output pfal_pkg::t_entry              o_wdata,
    output logic [ENT_W-1:0]              o_raddr
);
    import pfal_pkg::*;

    localparam int SLOT_W = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int OFF_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int FS_W   = $clog2(FILE_SLOTS + 1);
    localparam int CMP_W  = (FS_W > HANDLE_W) ? FS_W : HANDLE_W;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [SLOT_W-1:0]   r_slot;
    logic [ENT_W-1:0]    r_base;
    logic [UID_W-1:0]    r_uid;
    logic [PERM_W-1:0]   r_perm;
    logic [LEN_W-1:0]    r_len_q;
    logic [OFF_W-1:0]    r_idx, n_idx;
    logic [OFF_W-1:0]    r_hit, n_hit;
    t_status             r_status, n_status;
    logic                r_granted, n_granted;
    logic [SLOT_W-1:0]   r_clr_idx;
    logic [LEN_W-1:0]    r_len_mem [FILE_SLOTS];

    logic                w_accept;
    logic                w_handle_ok;
    logic [SLOT_W-1:0]   w_slot_in;
    logic [OFF_W-1:0]    w_last_off;
    logic                w_last;
    logic                w_len_we;
    logic [SLOT_W-1:0]   w_len_waddr;
    logic [LEN_W-1:0]    w_len_wdata;
    logic [SLOT_W-1:0]   w_len_raddr;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_handle_ok = (CMP_W'(i_handle) < CMP_W'(FILE_SLOTS)) &&
                         (i_handle < i_files_in_use);
    assign w_slot_in   = SLOT_W'(CMP_W'(i_handle));
    assign w_last_off  = OFF_W'(r_len_q - LEN_W'(1));
    assign w_last      = (r_idx == w_last_off);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == SLOT_W'(FILE_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if ((t_op'(i_operation) == OP_NONE) || !w_handle_ok) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_LCHK;
                    end
                end
            end
            S_LCHK: begin
                if ((r_op == OP_ADD) || (r_len_q == '0)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                priority if ((r_op == OP_REMOVE) && i_match.uid_eq) begin
                    n_state = S_MOVE;
                end else if ((r_op == OP_CHECK) && i_match.grant) begin
                    n_state = S_RESP;
                end else if (w_last) begin
                    n_state = S_RESP;
                end
            end
            S_MOVE:  n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_status    = r_status;
        n_granted   = r_granted;
        n_idx       = r_idx;
        n_hit       = r_hit;
        o_we        = 1'b0;
        o_waddr     = r_base;
        o_wdata     = i_rdata;
        o_raddr     = r_base;
        w_len_we    = 1'b0;
        w_len_waddr = r_slot;
        w_len_wdata = '0;
        w_len_raddr = r_slot;
        unique case (r_state)
            S_CLEAR: begin
                w_len_we    = 1'b1;
                w_len_waddr = r_clr_idx;
            end
            S_IDLE: begin
                w_len_raddr = w_slot_in;
                n_granted   = 1'b0;
                if ((t_op'(i_operation) != OP_NONE) && !w_handle_ok) begin
                    n_status = ST_BAD_HANDLE;
                end else begin
                    n_status = ST_OK;
                end
            end
            S_LCHK: begin
                n_idx = '0;
                if (r_op == OP_ADD) begin
                    if (r_len_q == LEN_W'(LIST_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_we         = 1'b1;
                        o_waddr      = r_base + ENT_W'(OFF_W'(r_len_q));
                        o_wdata.user = r_uid;
                        o_wdata.mask = r_perm;
                        w_len_we     = 1'b1;
                        w_len_wdata  = r_len_q + LEN_W'(1);
                    end
                end else if ((r_len_q == '0) && (r_op == OP_REMOVE)) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_SRCH: begin
                o_raddr = r_base + ENT_W'(r_idx);
                priority if ((r_op == OP_REMOVE) && i_match.uid_eq) begin
                    n_hit   = r_idx;
                    o_raddr = r_base + ENT_W'(w_last_off);
                end else if ((r_op == OP_CHECK) && i_match.grant) begin
                    n_granted = 1'b1;
                end else if (w_last) begin
                    if (r_op == OP_REMOVE) begin
                        n_status = ST_NOT_FOUND;
                    end
                end else begin
                    n_idx   = r_idx + OFF_W'(1);
                    o_raddr = r_base + ENT_W'(r_idx + OFF_W'(1));
                end
            end
            S_MOVE: begin
                o_we        = 1'b1;
                o_waddr     = r_base + ENT_W'(r_hit);
                w_len_we    = 1'b1;
                w_len_wdata = r_len_q - LEN_W'(1);
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_status  <= ST_OK;
            r_granted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_granted <= n_granted;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_hit <= n_hit;
        if (w_accept) begin
            r_op   <= t_op'(i_operation);
            r_slot <= w_slot_in;
            r_base <= ENT_W'(w_slot_in) * ENT_W'(LIST_DEPTH);
            r_uid  <= i_uid;
            r_perm <= i_perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_len_mem[w_len_waddr] <= w_len_wdata;
        end
        r_len_q <= r_len_mem[w_len_raddr];
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_valid   = (r_state == S_RESP);
    assign o_status  = r_status;
    assign o_granted = r_granted;
    assign o_uid     = r_uid;
    assign o_perm    = r_perm;

`ifndef ASSERT_OFF
    a_resp_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> (r_state == S_IDLE))
        else $error("result strobe held past one cycle");

    a_nop_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (t_op'(i_operation) == OP_NONE)) |=>
        ((r_state == S_RESP) && (r_status == ST_OK) && !r_granted))
        else $error("unused operation code not answered directly");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len_we |-> (w_len_wdata <= LEN_W'(LIST_DEPTH)))
        else $error("list length written past depth");

    a_srch_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> ((r_len_q != '0) && (r_op != OP_ADD)))
        else $error("walk over an empty list or for add");

    a_grant_check_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted) |-> ((r_op == OP_CHECK) && (r_status == ST_OK)))
        else $error("grant reported for a request other than check");
`endif

endmodule

/* sv/per_file_access_list_table.sv */
// ----------------------------------------------------------------------------
// per_file_access_list_table
// Access list per file slot: add, remove and check of user/permission entries.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive operation, handle, uid and perm with start high;
//   the request is taken on a clock edge where start is high and busy is low.
//   Result channel: o_valid pulses for one cycle with o_status and o_granted;
//   the receiver cannot stall and must take the result in that cycle.
//   Configuration: APB write of files_in_use at byte address 0, read back
//   at the same address; write only while busy is low.
// Steps: a bad handle or an unused operation goes straight to the result; add
//   reads the list length, then writes the entry and the new length unless the
//   list is full; check walks a non-empty list until a grant or its end; remove
//   walks until the user is found, then moves the last entry into its place.
//   Busy stays high with o_valid and drops in the cycle after it. A new request
//   is taken only after the last one is done; the list walk reads one entry per
//   cycle through the one read port of the entry memory and the shared compare
//   unit. Reset: a clearing pass zeroes every list length, one slot a cycle;
//   busy stays high until it ends.
// ----------------------------------------------------------------------------
module per_file_access_list_table #(
    parameter int FILE_SLOTS = 64,
    parameter int LIST_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pfal_pkg::OP_W-1:0]     i_operation,
    input  logic [pfal_pkg::HANDLE_W-1:0] i_handle,
    input  logic [pfal_pkg::UID_W-1:0]    i_uid,
    input  logic [pfal_pkg::PERM_W-1:0]   i_perm,
    output logic                          o_valid,
    output logic [pfal_pkg::STATUS_W-1:0] o_status,
    output logic                          o_granted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfal_pkg::APB_AW-1:0]   paddr,
    input  logic [pfal_pkg::APB_DW-1:0]   pwdata,
    output logic [pfal_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import pfal_pkg::*;

    localparam int ENT_DEPTH = FILE_SLOTS * LIST_DEPTH;
    localparam int ENT_W     = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int ENT_BITS  = $bits(t_entry);

    logic [FILES_W-1:0] r_files_in_use;
    logic               w_cfg_wr;

    t_match             w_match;
    t_entry             w_rdata;
    t_entry             w_wdata;
    logic [ENT_BITS-1:0] w_rdata_raw;
    logic               w_we;
    logic [ENT_W-1:0]   w_waddr;
    logic [ENT_W-1:0]   w_raddr;
    logic [UID_W-1:0]   w_key_uid;
    logic [PERM_W-1:0]  w_key_perm;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_files_in_use <= '0;
        end else if (w_cfg_wr && (paddr[2] == REG_FILES_IN_USE)) begin
            r_files_in_use <= pwdata[FILES_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_FILES_IN_USE) begin
            prdata = APB_DW'(r_files_in_use);
        end
    end

    assign w_rdata = t_entry'(w_rdata_raw);

    pfal_seq #(
        .FILE_SLOTS (FILE_SLOTS),
        .LIST_DEPTH (LIST_DEPTH),
        .ENT_W      (ENT_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_operation    (i_operation),
        .i_handle       (i_handle),
        .i_uid          (i_uid),
        .i_perm         (i_perm),
        .i_files_in_use (r_files_in_use),
        .i_match        (w_match),
        .i_rdata        (w_rdata),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_granted      (o_granted),
        .o_uid          (w_key_uid),
        .o_perm         (w_key_perm),
        .o_we           (w_we),
        .o_waddr        (w_waddr),
        .o_wdata        (w_wdata),
        .o_raddr        (w_raddr)
    );

    pfal_entry_ram #(
        .DEPTH  (ENT_DEPTH),
        .ADDR_W (ENT_W),
        .DATA_W (ENT_BITS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    pfal_match u_match (
        .i_uid   (w_key_uid),
        .i_perm  (w_key_perm),
        .i_entry (w_rdata),
        .o_match (w_match)
    );

endmodule

/* test/pfal_access_checker.sv */
// ----------------------------------------------------------------------------
// pfal_access_checker
// Watches the request, result and APB channels of the access list table,
// keeps its own copy of every slot's list and the file count, predicts
// status and grant for each accepted request and compares in order.
// ----------------------------------------------------------------------------
module pfal_access_checker #(
    parameter int FILE_SLOTS = 64,
    parameter int LIST_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [pfal_pkg::OP_W-1:0]     i_operation,
    input  logic [pfal_pkg::HANDLE_W-1:0] i_handle,
    input  logic [pfal_pkg::UID_W-1:0]    i_uid,
    input  logic [pfal_pkg::PERM_W-1:0]   i_perm,
    input  logic                          o_valid,
    input  logic [pfal_pkg::STATUS_W-1:0] o_status,
    input  logic                          o_granted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pfal_pkg::APB_AW-1:0]   paddr,
    input  logic [pfal_pkg::APB_DW-1:0]   pwdata,
    input  logic [pfal_pkg::APB_DW-1:0]   prdata,
    input  logic                          pready,
    output int                            o_pending,
    output int                            o_mismatches,
    output int                            o_results,
    output int                            o_grants,
    output int                            o_full_hits,
    output int                            o_not_found,
    output int                            o_bad_handles
);
    import pfal_pkg::*;

    localparam logic [APB_AW-1:0] FILES_ADDR = {REG_FILES_IN_USE, 2'b00};

    typedef struct packed {
        t_status status;
        logic    granted;
    } t_access_result;

    logic [UID_W-1:0]   entry_user [FILE_SLOTS*LIST_DEPTH];
    logic [PERM_W-1:0]  entry_mask [FILE_SLOTS*LIST_DEPTH];
    int unsigned        list_len   [FILE_SLOTS];
    logic [FILES_W-1:0] files_in_use;

    t_access_result expected_results [$];

    initial begin
        o_pending     = 0;
        o_mismatches  = 0;
        o_results     = 0;
        o_grants      = 0;
        o_full_hits   = 0;
        o_not_found   = 0;
        o_bad_handles = 0;
        files_in_use  = '0;
        for (int k = 0; k < FILE_SLOTS; k++) list_len[k] = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_mismatches < 100)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     o_results, what, got, want);
        o_mismatches++;
    endtask

    task automatic predict_access(input t_op op, input logic [HANDLE_W-1:0] handle,
                                  input logic [UID_W-1:0] uid,
                                  input logic [PERM_W-1:0] perm,
                                  output t_status status, output logic granted);
        int unsigned len;
        int unsigned base;
        int unsigned last;
        bit          found;
        status  = ST_OK;
        granted = 1'b0;
        found   = 1'b0;
        if (op == OP_NONE) begin
            return;
        end
        if (handle >= files_in_use || handle >= FILE_SLOTS) begin
            status = ST_BAD_HANDLE;
            return;
        end
        len  = list_len[handle];
        base = handle * LIST_DEPTH;
        case (op)
            OP_ADD: begin
                if (len >= LIST_DEPTH) begin
                    status = ST_FULL;
                end else begin
                    entry_user[base+len] = uid;
                    entry_mask[base+len] = perm;
                    list_len[handle]     = len + 1;
                end
            end
            OP_REMOVE: begin
                last = base + len - 1;
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (i < len && !found && entry_user[base+i] == uid) begin
                        entry_user[base+i] = entry_user[last];
                        entry_mask[base+i] = entry_mask[last];
                        list_len[handle]   = len - 1;
                        found              = 1'b1;
                    end
                end
                if (!found) status = ST_NOT_FOUND;
            end
            default: begin
                for (int i = 0; i < LIST_DEPTH; i++) begin
                    if (i < len && entry_user[base+i] == uid &&
                        (entry_mask[base+i] & perm) != '0)
                        granted = 1'b1;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_access_result got_exp;
        t_access_result next_exp;
        t_status        st;
        logic           gr;
        if (!i_rst_n) begin
            expected_results.delete();
            for (int k = 0; k < FILE_SLOTS; k++) list_len[k] = 0;
            files_in_use = '0;
        end else begin
            if (o_valid === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending", o_status, 0);
                end else begin
                    got_exp = expected_results.pop_front();
                    if (o_status !== got_exp.status)
                        report_mismatch("status", o_status, got_exp.status);
                    if (o_granted !== got_exp.granted)
                        report_mismatch("granted", o_granted, got_exp.granted);
                    if (got_exp.granted) o_grants++;
                    case (got_exp.status)
                        ST_FULL:       o_full_hits++;
                        ST_NOT_FOUND:  o_not_found++;
                        ST_BAD_HANDLE: o_bad_handles++;
                        default: ;
                    endcase
                end
                o_results++;
            end
            if (start === 1'b1 && busy === 1'b0) begin
                predict_access(t_op'(i_operation), i_handle, i_uid, i_perm, st, gr);
                next_exp.status  = st;
                next_exp.granted = gr;
                expected_results.push_back(next_exp);
            end
            if (psel && penable && pready && paddr == FILES_ADDR) begin
                if (pwrite)
                    files_in_use = pwdata[FILES_W-1:0];
                else if (prdata !== APB_DW'(files_in_use))
                    report_mismatch("files_in_use readback", prdata, files_in_use);
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* test/per_file_access_list_table_tb.sv */
// ----------------------------------------------------------------------------
// per_file_access_list_table_tb
// Drives add, remove and check requests and file count writes into the
// access list table: a directed opening over full, empty, missing-user and
// bad-handle cases, then random phases at several file counts with random
// gaps. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module per_file_access_list_table_tb;
    import pfal_pkg::*;

    localparam int FILE_SLOTS = 64;
    localparam int LIST_DEPTH = 8;
    localparam logic [APB_AW-1:0] FILES_ADDR = {REG_FILES_IN_USE, 2'b00};

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_operation = '0;
    logic [HANDLE_W-1:0] i_handle    = '0;
    logic [UID_W-1:0]    i_uid       = '0;
    logic [PERM_W-1:0]   i_perm      = '0;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_granted;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [APB_AW-1:0]   paddr       = '0;
    logic [APB_DW-1:0]   pwdata      = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    int pending;
    int mismatches;
    int results;
    int grants;
    int full_hits;
    int not_found;
    int bad_handles;
    int settings;

    logic [UID_W-1:0] uid_pool [8];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    per_file_access_list_table #(
        .FILE_SLOTS(FILE_SLOTS),
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_handle(i_handle), .i_uid(i_uid),
        .i_perm(i_perm), .o_valid(o_valid), .o_status(o_status),
        .o_granted(o_granted), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pfal_access_checker #(
        .FILE_SLOTS(FILE_SLOTS),
        .LIST_DEPTH(LIST_DEPTH)
    ) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_operation(i_operation), .i_handle(i_handle), .i_uid(i_uid),
        .i_perm(i_perm), .o_valid(o_valid), .o_status(o_status),
        .o_granted(o_granted), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_pending(pending), .o_mismatches(mismatches), .o_results(results),
        .o_grants(grants), .o_full_hits(full_hits), .o_not_found(not_found),
        .o_bad_handles(bad_handles)
    );

    task automatic send_request(input t_op op, input logic [HANDLE_W-1:0] h,
                                input logic [UID_W-1:0] uid,
                                input logic [PERM_W-1:0] perm, input int gap);
        i_operation <= op;
        i_handle    <= h;
        i_uid       <= uid;
        i_perm      <= perm;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold off until every request has its result and the block is idle
    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy !== 1'b0);
    endtask

    task automatic set_files_in_use(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FILES_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings++;
    endtask

    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_random(input int n_files, input bit burst);
        int                  r;
        int                  span;
        t_op                 op;
        logic [HANDLE_W-1:0] h;
        logic [UID_W-1:0]    uid;
        logic [PERM_W-1:0]   perm;
        span = (n_files > 0) ? n_files : 1;
        r = $urandom_range(0, 99);
        if (r < 40)      op = OP_ADD;
        else if (r < 70) op = OP_REMOVE;
        else if (r < 95) op = OP_CHECK;
        else             op = OP_NONE;
        r = $urandom_range(0, 99);
        if (r < 45)      h = HANDLE_W'($urandom_range(0, 2) % span);
        else if (r < 55) h = HANDLE_W'(span - 1);
        else if (r < 80) h = HANDLE_W'($urandom_range(0, span - 1));
        else if (r < 92) h = HANDLE_W'($urandom_range(0, 127));
        else             h = HANDLE_W'(n_files + $urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) uid = uid_pool[$urandom_range(0, 7)];
        else                           uid = $urandom;
        case ($urandom_range(0, 4))
            0:       perm = $urandom;
            1:       perm = 32'h1 << $urandom_range(0, 31);
            2:       perm = '0;
            3:       perm = '1;
            default: perm = $urandom & $urandom;
        endcase
        send_request(op, h, uid, perm, pick_gap(burst));
    endtask

    initial begin
        int  n_files;
        int  n_items;
        bit  burst;
        settings = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // no valid slots yet
        send_request(OP_ADD, 7'd0, 32'h0, 32'h1, 0);
        send_request(OP_CHECK, 7'd0, 32'h0, 32'h1, 2);
        send_request(OP_NONE, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        wait_idle();
        set_files_in_use(FILE_SLOTS);

        send_request(OP_ADD, 7'd0, 32'h0, 32'h0, 0);
        send_request(OP_ADD, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_request(OP_ADD, 7'd0, 32'hFFFF_FFFF, 32'h0, 0);
        send_request(OP_CHECK, 7'd0, 32'hFFFF_FFFF, 32'h8000_0000, 3);
        send_request(OP_CHECK, 7'd0, 32'h0, 32'hFFFF_FFFF, 0);
        send_request(OP_REMOVE, 7'd0, 32'h0001_2345, 32'h0, 0);
        send_request(OP_REMOVE, 7'd0, 32'hFFFF_FFFF, 32'h0, 1);
        send_request(OP_CHECK, 7'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_request(OP_REMOVE, 7'd0, 32'h0, 32'h0, 0);
        for (int k = 0; k <= LIST_DEPTH; k++)
            send_request(OP_ADD, 7'd63, 32'h1000 + k, 32'h1 << k, k % 3);
        send_request(OP_CHECK, 7'd64, 32'h1000, 32'hFFFF_FFFF, 0);
        send_request(OP_REMOVE, 7'd127, 32'h1000, 32'h0, 0);
        send_request(OP_NONE, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin n_files = 64; n_items = 300; end
                1: begin n_files = 1;  n_items = 200; end
                2: begin n_files = 0;  n_items = 40;  end
                3: begin n_files = 37; n_items = 300; end
                4: begin n_files = 64; n_items = 250; end
                5: begin n_files = 63; n_items = 300; end
                6: begin n_files = 2;  n_items = 160; end
                default: begin n_files = $urandom_range(0, 64); n_items = 300; end
            endcase
            uid_pool[0] = '0;
            uid_pool[1] = '1;
            for (int k = 2; k < 8; k++) uid_pool[k] = $urandom;
            wait_idle();
            set_files_in_use(n_files);
            burst = 1'b0;
            for (int n = 0; n < n_items; n++) begin
                if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 59) == 0) wait_idle();
                send_random(n_files, burst);
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests over %0d file-count settings", results, settings);
        $display("seen %0d grants, %0d full lists, %0d missing users, %0d bad handles",
                 grants, full_hits, not_found, bad_handles);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
